/* sv/sdtp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdtp_pkg
// Request and result types, phase codes and character constants for the
// strict decimal token parser.
// ----------------------------------------------------------------------------
package sdtp_pkg;

	localparam int OUT_BITS = 32;

	localparam logic [1:0] PH_SPACE  = 2'd0;
	localparam logic [1:0] PH_SIGNED = 2'd1;
	localparam logic [1:0] PH_DIGITS = 2'd2;
	localparam logic [1:0] PH_ERROR  = 2'd3;

	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef struct packed {
		logic [7:0] char_code;
		logic       token_end;
	} req_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] value;
		logic                       error;
	} rsp_t;

	typedef struct packed {
		logic [1:0] phase;
		logic       negative;
	} ctl_t;

endpackage

/* sv/sdtp_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdtp_step
// One character update: phase and sign update, checked multiply by ten and
// digit add, and the final range check and value at the token end.
// ----------------------------------------------------------------------------
module sdtp_step
	import sdtp_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  req_t                  req,
	input  ctl_t                  ctl,
	input  logic [VALUE_BITS-1:0] acc,
	output ctl_t                  ctl_next,
	output logic [VALUE_BITS-1:0] acc_next,
	output rsp_t                  rsp
);

	localparam logic [VALUE_BITS-1:0] POS_LIMIT = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic [VALUE_BITS-1:0] LIMIT_DIV10 = POS_LIMIT / VALUE_BITS'(10);
	localparam logic [VALUE_BITS-1:0] NEG_LIMIT = POS_LIMIT + 1'b1;

	logic                  is_space;
	logic                  is_digit;
	logic                  is_sign;
	logic                  ovf;
	logic [VALUE_BITS-1:0] acc_digit;
	logic [VALUE_BITS-1:0] mag;
	logic [VALUE_BITS+OUT_BITS-1:0] value_ext;
	logic                  ok;

	assign is_space = (req.char_code == CH_SPACE) ||
		((req.char_code >= CH_TAB) && (req.char_code <= CH_CR));
	assign is_digit = (req.char_code >= CH_ZERO) && (req.char_code <= CH_NINE);
	assign is_sign  = (req.char_code == CH_PLUS) || (req.char_code == CH_MINUS);
	assign ovf      = acc > LIMIT_DIV10;
	assign acc_digit = (acc << 3) + (acc << 1) +
		VALUE_BITS'(req.char_code[3:0] - CH_ZERO[3:0]);

	always_comb begin
		ctl_next = ctl;
		acc_next = acc;
		case (ctl.phase)
			PH_SPACE: begin
				if (is_space) begin
					ctl_next.phase = PH_SPACE;
				end else if (is_sign) begin
					ctl_next.negative = (req.char_code == CH_MINUS);
					ctl_next.phase    = PH_SIGNED;
				end else if (is_digit && !ovf) begin
					acc_next       = acc_digit;
					ctl_next.phase = PH_DIGITS;
				end else begin
					ctl_next.phase = PH_ERROR;
				end
			end
			PH_SIGNED, PH_DIGITS: begin
				if (is_digit && !ovf) begin
					acc_next       = acc_digit;
					ctl_next.phase = PH_DIGITS;
				end else begin
					ctl_next.phase = PH_ERROR;
				end
			end
			default: begin
				ctl_next.phase = PH_ERROR;
			end
		endcase
	end

	always_comb begin
		ok  = (ctl_next.phase == PH_DIGITS) &&
			(ctl_next.negative ? (acc_next <= NEG_LIMIT) : (acc_next <= POS_LIMIT));
		mag = ctl_next.negative ? (~acc_next + 1'b1) : acc_next;
		value_ext = {{OUT_BITS{1'b0}}, mag};
		rsp.value = ok ? value_ext[OUT_BITS-1:0] : '0;
		rsp.error = !ok;
	end

endmodule

/* sv/strict_decimal_token_parser_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_decimal_token_parser_core
// Parses a stream of characters into signed decimal values, one result per
// token, with an error flag for malformed or out-of-range tokens.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  req     | req_valid, req_stall | req_data  (char_code, token_end)
//  rsp     | rsp_valid, rsp_stall | rsp_data  (value, error)
//
//  One character per cycle while req_stall is low; a result is held in the result register until it is taken.
//  The input register feeds one pass of the step logic into the result register.
//  arst_n clears the phase, sign, accumulator and both valid flags.
//  req_stall rises only while a token end waits on a stalled, full result register.
// ----------------------------------------------------------------------------
module strict_decimal_token_parser_core
	import sdtp_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_data,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp_data
);

	logic                  valid_s1;
	req_t                  req_s1;
	ctl_t                  ctl_q;
	logic [VALUE_BITS-1:0] acc_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	ctl_t                  ctl_next;
	logic [VALUE_BITS-1:0] acc_next;
	rsp_t                  rsp_next;
	logic                  advance;
	logic                  load_rsp;

	sdtp_step #(
		.VALUE_BITS(VALUE_BITS)
	) u_step (
		.req      (req_s1),
		.ctl      (ctl_q),
		.acc      (acc_q),
		.ctl_next (ctl_next),
		.acc_next (acc_next),
		.rsp      (rsp_next)
	);

	assign advance   = valid_s1 && (!req_s1.token_end || !rsp_valid_q || !rsp_stall);
	assign load_rsp  = advance && req_s1.token_end;
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '{phase: PH_SPACE, negative: 1'b0};
			acc_q <= '0;
		end else if (advance) begin
			if (req_s1.token_end) begin
				ctl_q <= '{phase: PH_SPACE, negative: 1'b0};
				acc_q <= '0;
			end else begin
				ctl_q <= ctl_next;
				acc_q <= acc_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

`ifndef SYNTHESIS
	localparam logic [VALUE_BITS-1:0] ACC_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}} + 4'd9;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.error |-> rsp_q.value == '0)
		else $error("error result carries a nonzero value");

	a_space_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q.phase == PH_SPACE |-> acc_q == '0 && !ctl_q.negative)
		else $error("state not clear in whitespace phase");

	a_signed_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q.phase == PH_SIGNED |-> acc_q == '0)
		else $error("accumulator not clear after sign");

	a_acc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q <= ACC_MAX)
		else $error("accumulator above limit plus nine");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && req_s1.token_end && rsp_valid_q && rsp_stall)
		else $error("request stalled without a blocked result");
`endif

endmodule

/* test/strict_decimal_token_parser_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_decimal_token_parser_core_tb
// Streams character tokens into the parser: whitespace, signs, boundary values,
// scan overflow, stray bytes and broken tokens. The parsed value and error flag
// of every token are predicted and compared with the core's result, under
// four sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module strict_decimal_token_parser_core_tb;
	import sdtp_pkg::*;

	localparam int VALUE_BITS = 32;
	localparam logic [63:0] POS_LIMIT = (64'd1 << (VALUE_BITS - 1)) - 64'd1;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_CHARS = 185;

	class token_scoreboard;
		rsp_t        expected_q[$];
		logic [1:0]  phase;
		logic        negative;
		logic [63:0] magnitude;
		int          errors;
		int          results_seen;
		int          error_results;

		function new();
			phase = PH_SPACE;
			negative = 1'b0;
			magnitude = '0;
			errors = 0;
			results_seen = 0;
			error_results = 0;
		endfunction

		function logic [1:0] append_digit(logic [7:0] c);
			if (magnitude > POS_LIMIT / 10)
				return PH_ERROR;
			magnitude = magnitude * 10 + 64'(c - CH_ZERO);
			return PH_DIGITS;
		endfunction

		function void note_request(req_t r);
			logic [7:0] c;
			logic       is_digit;
			logic       is_space;
			rsp_t       res;
			c = r.char_code;
			is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
			is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
			case (phase)
				PH_SPACE: begin
					if (is_space)
						phase = PH_SPACE;
					else if (c == CH_PLUS || c == CH_MINUS) begin
						negative = (c == CH_MINUS);
						phase = PH_SIGNED;
					end else if (is_digit)
						phase = append_digit(c);
					else
						phase = PH_ERROR;
				end
				PH_SIGNED, PH_DIGITS: begin
					phase = is_digit ? append_digit(c) : PH_ERROR;
				end
				default: begin
				end
			endcase
			if (!r.token_end)
				return;
			res.value = '0;
			res.error = 1'b1;
			if (phase == PH_DIGITS) begin
				if (negative && magnitude <= POS_LIMIT + 64'd1) begin
					res.value = -magnitude[OUT_BITS-1:0];
					res.error = 1'b0;
				end else if (!negative && magnitude <= POS_LIMIT) begin
					res.value = magnitude[OUT_BITS-1:0];
					res.error = 1'b0;
				end
			end
			expected_q.push_back(res);
			phase = PH_SPACE;
			negative = 1'b0;
			magnitude = '0;
		endfunction

		function void check_result(rsp_t r);
			rsp_t e;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result with no token pending: value=%0d error=%0b",
					$time, r.value, r.error);
				return;
			end
			e = expected_q.pop_front();
			results_seen++;
			if (e.error)
				error_results++;
			if (r.value !== e.value) begin
				errors++;
				$display("%0t: value mismatch: expected %0d, actual %0d",
					$time, e.value, r.value);
			end
			if (r.error !== e.error) begin
				errors++;
				$display("%0t: error flag mismatch: expected %0b, actual %0b",
					$time, e.error, r.error);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_data;

	token_scoreboard sb;
	logic [7:0]      token_chars[$];
	int              idle_pct = 0;
	int              stall_pct = 0;
	int              sent_chars = 0;
	int              sent_tokens = 0;
	int              cycles = 0;

	strict_decimal_token_parser_core #(
		.VALUE_BITS(VALUE_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results pending", $time, sb.expected_q.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_result(rsp_data);
	end

	task automatic send_request(req_t r);
		int gap;
		gap = 0;
		while (idle_pct != 0 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_request(r);
		sent_chars++;
	endtask

	task automatic send_token();
		req_t r;
		for (int i = 0; i < token_chars.size(); i++) begin
			r.char_code = token_chars[i];
			r.token_end = (i == token_chars.size() - 1);
			send_request(r);
		end
		token_chars.delete();
		sent_tokens++;
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			token_chars.push_back(s[i]);
	endtask

	task automatic send_random_token();
		logic [63:0] mag;
		logic [7:0]  digits[$];
		int          kind;
		kind = $urandom_range(99);
		if (kind < 25) begin
			repeat ($urandom_range(1, 5))
				token_chars.push_back(8'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(0, 2)) begin
				if ($urandom_range(1))
					token_chars.push_back(CH_SPACE);
				else
					token_chars.push_back(8'($urandom_range(CH_TAB, CH_CR)));
			end
			case ($urandom_range(3))
				0: token_chars.push_back(CH_PLUS);
				1: token_chars.push_back(CH_MINUS);
				default: begin
				end
			endcase
			case ($urandom_range(5))
				0: mag = POS_LIMIT - 64'd1 + 64'($urandom_range(3));
				1: mag = 64'($urandom());
				2: mag = 64'($urandom_range(999));
				3: mag = '0;
				4: mag = {$urandom(), $urandom()} % 64'd1000000000000;
				default: mag = POS_LIMIT - 64'd7 + 64'($urandom_range(9));
			endcase
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(1, 3)) token_chars.push_back(CH_ZERO);
			do begin
				digits.push_front(CH_ZERO + 8'(mag % 10));
				mag = mag / 10;
			end while (mag != 0);
			foreach (digits[i])
				token_chars.push_back(digits[i]);
			// break a share of the well-formed tokens
			if (kind < 37) begin
				case ($urandom_range(2))
					0: token_chars[$urandom_range(token_chars.size() - 1)] =
						8'($urandom_range(255));
					1: token_chars.push_back($urandom_range(1) ? CH_SPACE : CH_MINUS);
					default: token_chars.push_back(8'($urandom_range(255)));
				endcase
			end
		end
		send_token();
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.expected_q.size() != 0);
	endtask

	task automatic run_phase(int sender_idle, int receiver_stall);
		int target;
		idle_pct = sender_idle;
		stall_pct = receiver_stall;
		target = sent_chars + PHASE_CHARS;
		while (sent_chars < target)
			send_random_token();
		wait_drained();
	endtask

	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		token_chars.push_back(CH_TAB);
		token_chars.push_back(CH_CR);
		add_text("-9");
		send_token();
		add_text("0");
		send_token();
		add_text("+");
		send_token();
		add_text(" ");
		send_token();
		add_text("1 ");
		send_token();
		add_text("-+5");
		send_token();
		token_chars.push_back(8'h00);
		add_text("7");
		send_token();
		token_chars.push_back(8'hFF);
		send_token();
		add_text("9999999999");
		send_token();
		wait_drained();

		run_phase(0, 0);
		run_phase(86, 0);
		run_phase(0, 86);
		run_phase(6, 6);

		repeat (8) @(posedge clk);
		$display("Sent %0d characters in %0d tokens; checked %0d results, %0d of them errors,",
			sent_chars, sent_tokens, sb.results_seen, sb.error_results);
		$display("across free-running, idle-sender, stalled-receiver and light-idling phases.");
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* files.f */
sv/sdtp_pkg.sv
sv/sdtp_step.sv
sv/strict_decimal_token_parser_core.sv
test/strict_decimal_token_parser_core_tb.sv
